// ----- src/bfl_pkg.sv -----
// ----------------------------------------------------------------------------
// bfl_pkg
// Shared types and constants for the horizontal box filter line pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bfl_pkg;

  localparam int unsigned ChanW      = 8;
  localparam int unsigned NumChan    = 3;
  localparam int unsigned PixW       = ChanW * NumChan;
  localparam int unsigned SumW       = 15;
  localparam int unsigned RadW       = 6;
  localparam int unsigned WinW       = RadW + 1;
  localparam int unsigned RadCount   = 1 << RadW;
  localparam int unsigned RecipShift = SumW + WinW;
  localparam int unsigned RecipW     = RecipShift + 1;
  localparam int unsigned ProdW      = SumW + RecipW;

  typedef logic [ChanW-1:0]              chan_t;
  // index 0 red, 1 green, 2 blue
  typedef logic [NumChan-1:0][ChanW-1:0] pixel_t;
  typedef logic [SumW-1:0]               sum_t;
  typedef logic [NumChan-1:0][SumW-1:0]  sum3_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_FIX,
    S_MUL,
    S_EMIT
  } state_e;

endpackage

`default_nettype wire

// ----- src/box_filter_line_pass.sv -----
// ----------------------------------------------------------------------------
// box_filter_line_pass
// One horizontal box blur pass over a line of RGB pixels, window clamped to
// the edge pixels. Running sums per channel, pixel history in one RAM.
// ----------------------------------------------------------------------------
// Flow: each input beat passes S_IDLE and S_SUM, then S_MUL and S_EMIT when an output
//   is due; no new beat is taken until the state is back in S_IDLE, and S_EMIT waits
//   for the output register to be free. The sum update waits on the registered history
//   RAM read, then the reciprocal multiply. The line-end beat flushes up to r+1 outputs,
//   one S_MUL/S_EMIT pass each, plus an S_FIX step when the line holds no more than r pixels.
// Reset: sums and line position cleared, radius 1; history RAM not cleared.
`timescale 1ns / 1ps
`default_nettype none

module box_filter_line_pass #(
  parameter int unsigned MAX_RADIUS    = 63,
  parameter int unsigned HISTORY_DEPTH = 128,
  parameter int unsigned MAX_LINE      = 4096
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output      logic                       s_axis_tready,
  input  wire logic [23:0]                s_axis_tdata,  // red_in, green_in, blue_in
  input  wire logic                       s_axis_tlast,  // line_end_in
  output      logic                       m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output      logic [23:0]                m_axis_tdata,  // red_out, green_out, blue_out
  output      logic                       m_axis_tlast,  // line_end_out
  input  wire logic                       cfg_we_i,
  input  wire logic [bfl_pkg::RadW-1:0]   cfg_wdata_i    // radius
);

  localparam int unsigned AW     = $clog2(HISTORY_DEPTH);
  localparam int unsigned PosW   = $clog2(MAX_LINE);
  localparam int unsigned CmpW   = PosW + 8;
  localparam int unsigned HalfD  = (HISTORY_DEPTH - 1) / 2;
  localparam int unsigned RLim   = (MAX_RADIUS < HalfD) ? MAX_RADIUS : HalfD;
  localparam int unsigned SumW   = bfl_pkg::SumW;
  localparam int unsigned NumCh  = bfl_pkg::NumChan;

  bfl_pkg::state_e state_q, state_d;

  logic [bfl_pkg::RadW-1:0] radius_q;
  logic [PosW-1:0]          n_q;
  logic [PosW-1:0]          i_q;
  logic [AW-1:0]            wp_q;
  logic [AW-1:0]            rp_q;
  bfl_pkg::sum3_t           sum_q;
  logic                     flush_q;
  logic                     out_vld_q;

  bfl_pkg::pixel_t          pix_q;
  bfl_pkg::pixel_t          p0_q;
  bfl_pkg::pixel_t          rd_q;
  bfl_pkg::pixel_t          out_pix_q;
  logic                     out_last_q;
  logic                     last_q;
  bfl_pkg::sum3_t           t_q;
  bfl_pkg::pixel_t          hist_mem_q [HISTORY_DEPTH];

  logic                     acc;
  logic                     acc_last;
  logic                     mem_rd_en;
  logic [AW-1:0]            mem_rd_addr;
  logic                     div_en;
  logic                     out_free;
  logic                     out_load;
  logic                     emit_last;

  logic [bfl_pkg::RadW-1:0] r_eff;
  logic [bfl_pkg::WinW-1:0] w;
  logic [CmpW-1:0]          n_x;
  logic [CmpW-1:0]          i_x;
  logic [CmpW-1:0]          r_x;
  logic                     n_ge_r;
  logic [AW:0]              old_sum;
  logic [AW-1:0]            old_addr;
  logic [AW:0]              rp_sum;
  logic [AW-1:0]            rp_start;
  logic [bfl_pkg::RadW-1:0] d;
  bfl_pkg::pixel_t          old_pix;
  bfl_pkg::pixel_t          sub_pix;
  bfl_pkg::pixel_t          in_pix;
  bfl_pkg::sum3_t           s_new;
  bfl_pkg::sum3_t           fix_t;
  bfl_pkg::sum3_t           step_t;
  bfl_pkg::pixel_t          quot;

  logic signed [bfl_pkg::ChanW:0]   diff     [NumCh];
  logic signed [bfl_pkg::ChanW+bfl_pkg::WinW:0] fix_prod [NumCh];

  assign in_pix = s_axis_tdata;
  assign r_eff  = (radius_q > bfl_pkg::RadW'(RLim)) ? bfl_pkg::RadW'(RLim) : radius_q;
  assign w      = {r_eff, 1'b1};
  assign n_x    = CmpW'(n_q);
  assign i_x    = CmpW'(i_q);
  assign r_x    = CmpW'(r_eff);
  assign n_ge_r = (n_x >= r_x);
  assign d      = bfl_pkg::RadW'(r_x - n_x);

  // slot of the pixel leaving the window: (n - w) mod depth
  assign old_sum  = {1'b0, wp_q} + (AW+1)'(HISTORY_DEPTH) - (AW+1)'(w);
  assign old_addr = (old_sum >= (AW+1)'(HISTORY_DEPTH)) ?
                    AW'(old_sum - (AW+1)'(HISTORY_DEPTH)) : AW'(old_sum);

  // first flush read slot: (n - 2r) mod depth, or (-r) mod depth near line start
  always_comb begin
    if (n_ge_r) begin
      rp_sum = {1'b0, wp_q} + (AW+1)'(HISTORY_DEPTH) - (AW+1)'({r_eff, 1'b0});
    end else begin
      rp_sum = (AW+1)'(HISTORY_DEPTH) - (AW+1)'(r_eff);
    end
    rp_start = (rp_sum >= (AW+1)'(HISTORY_DEPTH)) ?
               AW'(rp_sum - (AW+1)'(HISTORY_DEPTH)) : AW'(rp_sum);
  end

  assign old_pix = (n_x <= CmpW'(w)) ? p0_q : rd_q;
  assign sub_pix = (i_x <= r_x) ? p0_q : rd_q;

  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      if (n_q == '0) begin
        s_new[c] = SumW'(w) * SumW'(pix_q[c]);
      end else begin
        s_new[c] = sum_q[c] + SumW'(pix_q[c]) - SumW'(old_pix[c]);
      end
      diff[c]     = $signed({1'b0, pix_q[c]}) - $signed({1'b0, p0_q[c]});
      fix_prod[c] = diff[c] * $signed({1'b0, d});
      fix_t[c]    = sum_q[c] + fix_prod[c][SumW-1:0];
      step_t[c]   = t_q[c] + SumW'(pix_q[c]) - SumW'(sub_pix[c]);
    end
  end

  assign out_free  = !out_vld_q || m_axis_tready;
  assign emit_last = flush_q && (i_q == n_q);
  assign acc_last  = s_axis_tlast || (n_q == PosW'(MAX_LINE - 1));

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    acc           = 1'b0;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = old_addr;
    div_en        = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      bfl_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          acc       = 1'b1;
          mem_rd_en = 1'b1;
          state_d   = bfl_pkg::S_SUM;
        end
      end
      bfl_pkg::S_SUM: begin
        if (!last_q) begin
          state_d = n_ge_r ? bfl_pkg::S_MUL : bfl_pkg::S_IDLE;
        end else begin
          state_d = n_ge_r ? bfl_pkg::S_MUL : bfl_pkg::S_FIX;
        end
      end
      bfl_pkg::S_FIX: begin
        state_d = bfl_pkg::S_MUL;
      end
      bfl_pkg::S_MUL: begin
        div_en      = 1'b1;
        mem_rd_en   = 1'b1;
        mem_rd_addr = rp_q;
        state_d     = bfl_pkg::S_EMIT;
      end
      bfl_pkg::S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = (flush_q && !emit_last) ? bfl_pkg::S_MUL : bfl_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bfl_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfl_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= bfl_pkg::RadW'(1);
      n_q       <= '0;
      i_q       <= '0;
      wp_q      <= '0;
      rp_q      <= '0;
      sum_q     <= '0;
      flush_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        radius_q <= cfg_wdata_i;
        n_q      <= '0;
        wp_q     <= '0;
        sum_q    <= '0;
      end

      if (state_q == bfl_pkg::S_SUM) begin
        sum_q <= s_new;
        if (!last_q) begin
          n_q     <= n_q + PosW'(1);
          wp_q    <= (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
          flush_q <= 1'b0;
        end else begin
          flush_q <= 1'b1;
          rp_q    <= rp_start;
          i_q     <= n_ge_r ? PosW'(n_x - r_x) : '0;
        end
      end

      if (out_load && flush_q) begin
        if (emit_last) begin
          n_q     <= '0;
          wp_q    <= '0;
          sum_q   <= '0;
          flush_q <= 1'b0;
        end else begin
          i_q  <= i_q + PosW'(1);
          rp_q <= (rp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : rp_q + AW'(1);
        end
      end

      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      pix_q  <= in_pix;
      last_q <= acc_last;
      if (n_q == '0) begin
        p0_q <= in_pix;
      end
    end
    unique case (state_q)
      bfl_pkg::S_SUM:  t_q <= s_new;
      bfl_pkg::S_FIX:  t_q <= fix_t;
      bfl_pkg::S_EMIT: begin
        if (out_load) begin
          t_q <= step_t;
        end
      end
      default:         t_q <= t_q;
    endcase
    if (out_load) begin
      out_pix_q  <= quot;
      out_last_q <= emit_last;
    end
  end

  // history RAM, read-first
  always_ff @(posedge clk_i) begin
    if (acc) begin
      hist_mem_q[wp_q] <= in_pix;
    end
    if (mem_rd_en) begin
      rd_q <= hist_mem_q[mem_rd_addr];
    end
  end

  bfl_div u_div (
    .clk_i    (clk_i),
    .en_i     (div_en),
    .radius_i (r_eff),
    .sums_i   (t_q),
    .quot_o   (quot)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tlast  = out_last_q;

  a_flush_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bfl_pkg::S_EMIT && flush_q) |-> (i_q <= n_q))
    else $error("flush index passed line end");

  a_line_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= PosW'(MAX_LINE - 1))
    else $error("line position out of range");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, wp_q} < (AW+1)'(HISTORY_DEPTH)) && ({1'b0, rp_q} < (AW+1)'(HISTORY_DEPTH)))
    else $error("history pointer out of range");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |=> (out_vld_q && $stable(out_pix_q)))
    else $error("pending output beat overwritten");

endmodule

`default_nettype wire

// ----- src/bfl_div.sv -----
// ----------------------------------------------------------------------------
// bfl_div
// Divides three window sums by the window width 2r+1 with an exact
// reciprocal multiply; product registered, quotient read in the cycle after.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfl_div (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [bfl_pkg::RadW-1:0]   radius_i,
  input  wire bfl_pkg::sum3_t             sums_i,
  output      bfl_pkg::pixel_t            quot_o
);

  logic [bfl_pkg::RecipW-1:0] recip_tab [bfl_pkg::RadCount];
  logic [bfl_pkg::RecipW-1:0] recip;
  logic [bfl_pkg::NumChan-1:0][bfl_pkg::ProdW-1:0] prod_q;

  // ceil(2^shift / (2g+1)); exact floor for every 15-bit numerator
  for (genvar g = 0; g < bfl_pkg::RadCount; g++) begin : g_recip
    localparam longint unsigned Recip =
      ((64'd1 << bfl_pkg::RecipShift) + 2 * g) / (2 * g + 1);
    assign recip_tab[g] = bfl_pkg::RecipW'(Recip);
  end

  assign recip = recip_tab[radius_i];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < bfl_pkg::NumChan; c++) begin
        prod_q[c] <= bfl_pkg::ProdW'(sums_i[c]) * bfl_pkg::ProdW'(recip);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < bfl_pkg::NumChan; c++) begin
      quot_o[c] = prod_q[c][bfl_pkg::RecipShift +: bfl_pkg::ChanW];
    end
  end

endmodule

`default_nettype wire
